// ===== hw/rtl/triangle_edge_barycentric_core_assert.svh =====
// Assertion macros for the triangle edge and barycentric core.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef TRIANGLE_EDGE_BARYCENTRIC_CORE_ASSERT_SVH
`define TRIANGLE_EDGE_BARYCENTRIC_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TEB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked in the cycle after reset is sampled low.
`define TEB_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/teb_pkg.sv =====
// Shared types and constants for the triangle edge and barycentric core.
// No dependencies.
package teb_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 34;
  localparam int SUM_W     = 35;
  localparam int MAG_W     = 35;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } vertex_set_t;

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [MAG_W-1:0] num;
  } lane_prep_t;

  typedef struct packed {
    logic             hit;
    logic             degen;
    lane_prep_t       lane_a;
    lane_prep_t       lane_b;
    logic [MAG_W-1:0] den;
  } div_item_t;

  typedef struct packed {
    logic hit;
    logic degen;
    logic zero_a;
    logic sat_a;
    logic zero_b;
    logic sat_b;
  } div_flags_t;

endpackage

// ===== hw/rtl/teb_cfg_regs.sv =====
// Vertex register file of the triangle edge and barycentric core.
// Depends on teb_pkg.
module teb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [teb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [teb_pkg::COORD_W-1:0]     cfg_data,
  output teb_pkg::vertex_set_t            vtx
);
  import teb_pkg::*;

  vertex_set_t vtx_r;
  vertex_set_t vtx_nxt;

  // Writes are always taken: cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_comb begin
    vtx_nxt = vtx_r;
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_A_X: vtx_nxt.ax = cfg_data;
        REG_A_Y: vtx_nxt.ay = cfg_data;
        REG_B_X: vtx_nxt.bx = cfg_data;
        REG_B_Y: vtx_nxt.by = cfg_data;
        REG_C_X: vtx_nxt.cx = cfg_data;
        REG_C_Y: vtx_nxt.cy = cfg_data;
        default: vtx_nxt = vtx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r <= '0;
    end else begin
      vtx_r <= vtx_nxt;
    end
  end

  assign vtx = vtx_r;

endmodule

// ===== hw/rtl/teb_edge_pipe.sv =====
// Front pipeline: differences, products, edge sums and divider operand setup.
// Depends on teb_pkg.
module teb_edge_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  teb_pkg::coord_t      sample_x,
  input  teb_pkg::coord_t      sample_y,
  input  teb_pkg::vertex_set_t vtx,
  output logic                 out_valid,
  input  logic                 out_ready,
  output teb_pkg::div_item_t   out_item
);
  import teb_pkg::*;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  function automatic diff_t diff_of(input coord_t a, input coord_t b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic sum_t widen(input prod_t p);
    return {p[PROD_W-1], p};
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input sum_t v);
    sum_t neg;
    neg = -v;
    return v[SUM_W-1] ? MAG_W'(neg) : MAG_W'(v);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // Stage 1: vertex edge vectors and sample offsets.
  diff_t d_ab_x_r, d_ab_y_r, d_bc_x_r, d_bc_y_r, d_ca_x_r, d_ca_y_r;
  diff_t s_ax_r, s_ay_r, s_bx_r, s_by_r, s_cx_r, s_cy_r;

  // Stage 2: products.
  prod_t pe1_r, pe2_r, pe3_r, pe4_r, pe5_r, pe6_r;
  prod_t pd1_r, pd2_r, pa1_r, pa2_r;

  // Stage 3: sums.
  logic hit3_r;
  sum_t area3_r, na3_r, nb3_r;
  sum_t e_ab, e_bc, e_ca;
  logic hit3_nxt;

  // Stage 4: divider operands.
  div_item_t item4_r;
  div_item_t item4_nxt;
  logic [MAG_W-1:0] den_mag, na_mag, nb_mag;
  logic degen;

  // Each stage loads when it is empty or its item moves on.
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d_ab_x_r <= diff_of(vtx.ax, vtx.bx);
      d_ab_y_r <= diff_of(vtx.ay, vtx.by);
      d_bc_x_r <= diff_of(vtx.bx, vtx.cx);
      d_bc_y_r <= diff_of(vtx.by, vtx.cy);
      d_ca_x_r <= diff_of(vtx.cx, vtx.ax);
      d_ca_y_r <= diff_of(vtx.cy, vtx.ay);
      s_ax_r   <= diff_of(sample_x, vtx.ax);
      s_ay_r   <= diff_of(sample_y, vtx.ay);
      s_bx_r   <= diff_of(sample_x, vtx.bx);
      s_by_r   <= diff_of(sample_y, vtx.by);
      s_cx_r   <= diff_of(sample_x, vtx.cx);
      s_cy_r   <= diff_of(sample_y, vtx.cy);
    end
  end

  // The edge C->A shares its products with the numerator of B
  // (it is the same value with the opposite sign).
  always_ff @(posedge clk) begin
    if (en2) begin
      pe1_r <= d_ab_x_r * s_ay_r;
      pe2_r <= d_ab_y_r * s_ax_r;
      pe3_r <= d_bc_x_r * s_by_r;
      pe4_r <= d_bc_y_r * s_bx_r;
      pe5_r <= d_ca_x_r * s_cy_r;
      pe6_r <= d_ca_y_r * s_cx_r;
      pd1_r <= d_bc_x_r * d_ca_y_r;
      pd2_r <= d_bc_y_r * d_ca_x_r;
      pa1_r <= d_bc_y_r * s_cx_r;
      pa2_r <= d_bc_x_r * s_cy_r;
    end
  end

  always_comb begin
    e_ab     = widen(pe1_r) - widen(pe2_r);
    e_bc     = widen(pe3_r) - widen(pe4_r);
    e_ca     = widen(pe5_r) - widen(pe6_r);
    hit3_nxt = !e_ab[SUM_W-1] && !e_bc[SUM_W-1] && !e_ca[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      hit3_r  <= hit3_nxt;
      area3_r <= widen(pd1_r) - widen(pd2_r);
      na3_r   <= widen(pa1_r) - widen(pa2_r);
      nb3_r   <= widen(pe6_r) - widen(pe5_r);
    end
  end

  always_comb begin
    degen   = (area3_r == '0);
    den_mag = mag_of(area3_r);
    na_mag  = mag_of(na3_r);
    nb_mag  = mag_of(nb3_r);

    item4_nxt.hit   = hit3_r;
    item4_nxt.degen = degen;
    item4_nxt.den   = den_mag;

    // A weight is zero on a miss, a flat triangle, a zero numerator or
    // a numerator whose sign differs from the area's.
    item4_nxt.lane_a.zero = !hit3_r || degen || (na3_r == '0) ||
                            (na3_r[SUM_W-1] != area3_r[SUM_W-1]);
    item4_nxt.lane_a.sat  = (na_mag >= den_mag);
    item4_nxt.lane_a.num  = na_mag;

    item4_nxt.lane_b.zero = !hit3_r || degen || (nb3_r == '0) ||
                            (nb3_r[SUM_W-1] != area3_r[SUM_W-1]);
    item4_nxt.lane_b.sat  = (nb_mag >= den_mag);
    item4_nxt.lane_b.num  = nb_mag;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      item4_r <= item4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item4_r;

endmodule

// ===== hw/rtl/teb_div_pipe.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per stage. Depends on teb_pkg.
module teb_div_pipe #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  teb_pkg::div_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output teb_pkg::div_flags_t       out_flags,
  output logic [WEIGHT_FRAC_BITS:0] out_quot_a,
  output logic [WEIGHT_FRAC_BITS:0] out_quot_b
);
  import teb_pkg::*;

  // One quotient bit beyond the weight's fraction feeds the final rounding.
  localparam int QW   = WEIGHT_FRAC_BITS + 1;
  localparam int NSTG = QW;

  logic             v_r      [NSTG];
  div_flags_t       flags_r  [NSTG];
  logic [MAG_W-1:0] den_r    [NSTG];
  logic [MAG_W-1:0] rem_a_r  [NSTG];
  logic [MAG_W-1:0] rem_b_r  [NSTG];
  logic [QW-1:0]    quot_a_r [NSTG];
  logic [QW-1:0]    quot_b_r [NSTG];

  logic             v_nxt      [NSTG];
  div_flags_t       flags_nxt  [NSTG];
  logic [MAG_W-1:0] den_nxt    [NSTG];
  logic [MAG_W-1:0] rem_a_nxt  [NSTG];
  logic [MAG_W-1:0] rem_b_nxt  [NSTG];
  logic [QW-1:0]    quot_a_nxt [NSTG];
  logic [QW-1:0]    quot_b_nxt [NSTG];

  logic en [NSTG+1];

  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    logic             src_v;
    div_flags_t       src_f;
    logic [MAG_W-1:0] src_den;
    logic [MAG_W-1:0] src_ra;
    logic [MAG_W-1:0] src_rb;
    logic [QW-1:0]    src_qa;
    logic [QW-1:0]    src_qb;
    logic [MAG_W:0]   dbl_a;
    logic [MAG_W:0]   dbl_b;
    logic [MAG_W:0]   sub_a;
    logic [MAG_W:0]   sub_b;
    logic             ge_a;
    logic             ge_b;
    for (int k = 0; k < NSTG; k++) begin
      if (k == 0) begin
        src_v         = in_valid;
        src_f.hit     = in_item.hit;
        src_f.degen   = in_item.degen;
        src_f.zero_a  = in_item.lane_a.zero;
        src_f.sat_a   = in_item.lane_a.sat;
        src_f.zero_b  = in_item.lane_b.zero;
        src_f.sat_b   = in_item.lane_b.sat;
        src_den       = in_item.den;
        src_ra        = in_item.lane_a.num;
        src_rb        = in_item.lane_b.num;
        src_qa        = '0;
        src_qb        = '0;
      end else begin
        src_v   = v_r[k-1];
        src_f   = flags_r[k-1];
        src_den = den_r[k-1];
        src_ra  = rem_a_r[k-1];
        src_rb  = rem_b_r[k-1];
        src_qa  = quot_a_r[k-1];
        src_qb  = quot_b_r[k-1];
      end
      // The remainder stays below the divisor for every lane that is not
      // saturated or zeroed; other lanes carry don't-care values.
      dbl_a = {src_ra, 1'b0};
      dbl_b = {src_rb, 1'b0};
      sub_a = dbl_a - {1'b0, src_den};
      sub_b = dbl_b - {1'b0, src_den};
      ge_a  = (dbl_a >= {1'b0, src_den});
      ge_b  = (dbl_b >= {1'b0, src_den});

      v_nxt[k]      = src_v;
      flags_nxt[k]  = src_f;
      den_nxt[k]    = src_den;
      rem_a_nxt[k]  = ge_a ? sub_a[MAG_W-1:0] : dbl_a[MAG_W-1:0];
      rem_b_nxt[k]  = ge_b ? sub_b[MAG_W-1:0] : dbl_b[MAG_W-1:0];
      quot_a_nxt[k] = {src_qa[QW-2:0], ge_a};
      quot_b_nxt[k] = {src_qb[QW-2:0], ge_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        flags_r[k]  <= flags_nxt[k];
        den_r[k]    <= den_nxt[k];
        rem_a_r[k]  <= rem_a_nxt[k];
        rem_b_r[k]  <= rem_b_nxt[k];
        quot_a_r[k] <= quot_a_nxt[k];
        quot_b_r[k] <= quot_b_nxt[k];
      end
    end
  end

  assign out_valid  = v_r[NSTG-1];
  assign out_flags  = flags_r[NSTG-1];
  assign out_quot_a = quot_a_r[NSTG-1];
  assign out_quot_b = quot_b_r[NSTG-1];

endmodule

// ===== hw/rtl/triangle_edge_barycentric_core.sv =====
// Top level of the triangle edge and barycentric core: vertex registers,
// front pipeline, divider pipeline and output register. Depends on teb_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_sample_x, in_sample_y
//   out      output     out_valid / out_stall out_hit, out_degenerate, out_weight_a/b/c
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item enters per clock while in_stall is low. Each item passes four front
// stages, one divider stage per quotient bit (WEIGHT_FRAC_BITS + 1 of them)
// and the output register.
// Reset clears all valid bits and sets every vertex register to zero.
// A stall at the output holds the result; empty stages behind it keep
// filling, so input is taken until the pipeline is full.
module triangle_edge_barycentric_core #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [teb_pkg::COORD_W-1:0]     in_sample_x,
  input  logic [teb_pkg::COORD_W-1:0]     in_sample_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic                            out_degenerate,
  output logic [WEIGHT_FRAC_BITS:0]       out_weight_a,
  output logic [WEIGHT_FRAC_BITS:0]       out_weight_b,
  output logic [WEIGHT_FRAC_BITS:0]       out_weight_c,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [teb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [teb_pkg::COORD_W-1:0]     cfg_data
);
  import teb_pkg::*;

  localparam int WW = WEIGHT_FRAC_BITS + 1;
  localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  vertex_set_t vtx;
  logic        front_ready;
  logic        mid_valid;
  logic        mid_ready;
  div_item_t   mid_item;
  logic        div_valid;
  logic        div_ready;
  div_flags_t  div_flags;
  logic [WW-1:0] quot_a;
  logic [WW-1:0] quot_b;

  logic          out_valid_r;
  logic          out_hit_r;
  logic          out_degen_r;
  logic [WW-1:0] wa_r, wb_r, wc_r;
  logic [WW-1:0] wa_nxt, wb_nxt, wc_nxt;
  logic [WW:0]   rnd_a, rnd_b;
  logic signed [WW+1:0] wc_full;
  logic          out_en;

  teb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx)
  );

  teb_edge_pipe u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .sample_x  (coord_t'(in_sample_x)),
    .sample_y  (coord_t'(in_sample_y)),
    .vtx       (vtx),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  teb_div_pipe #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_item    (mid_item),
    .out_valid  (div_valid),
    .out_ready  (div_ready),
    .out_flags  (div_flags),
    .out_quot_a (quot_a),
    .out_quot_b (quot_b)
  );

  assign in_stall  = !front_ready;
  assign out_en    = !out_valid_r || !out_stall;
  assign div_ready = out_en;

  // The quotient carries one extra bit; adding one and dropping it rounds
  // to nearest with ties up.
  always_comb begin
    rnd_a  = {1'b0, quot_a} + {{WW{1'b0}}, 1'b1};
    rnd_b  = {1'b0, quot_b} + {{WW{1'b0}}, 1'b1};
    wa_nxt = div_flags.zero_a ? '0 : (div_flags.sat_a ? WEIGHT_ONE : rnd_a[WW:1]);
    wb_nxt = div_flags.zero_b ? '0 : (div_flags.sat_b ? WEIGHT_ONE : rnd_b[WW:1]);
    wc_full = $signed({2'b00, WEIGHT_ONE}) - $signed({2'b00, wa_nxt})
              - $signed({2'b00, wb_nxt});
    if (!div_flags.hit || div_flags.degen || wc_full[WW+1]) begin
      wc_nxt = '0;
    end else begin
      wc_nxt = wc_full[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_hit_r   <= div_flags.hit;
      out_degen_r <= div_flags.degen;
      wa_r        <= wa_nxt;
      wb_r        <= wb_nxt;
      wc_r        <= wc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_degenerate = out_degen_r;
  assign out_weight_a   = wa_r;
  assign out_weight_b   = wb_r;
  assign out_weight_c   = wc_r;

endmodule

// ===== hw/rtl/teb_checker.sv =====
// Port-level checker for the triangle edge and barycentric core, bound to
// the top level. Depends on triangle_edge_barycentric_core_assert.svh.
`include "triangle_edge_barycentric_core_assert.svh"

module teb_checker #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_hit,
  input logic                      out_degenerate,
  input logic [WEIGHT_FRAC_BITS:0] out_weight_a,
  input logic [WEIGHT_FRAC_BITS:0] out_weight_b,
  input logic [WEIGHT_FRAC_BITS:0] out_weight_c
);

  localparam int WW = WEIGHT_FRAC_BITS + 1;
  localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
  localparam logic [WW+1:0] SUM_ONE = {2'b00, WEIGHT_ONE};

  logic [WW+1:0] weight_sum;
  logic          weights_zero;
  logic          weights_capped;

  assign weight_sum = {2'b00, out_weight_a} + {2'b00, out_weight_b}
                      + {2'b00, out_weight_c};
  assign weights_zero = (out_weight_a == '0) && (out_weight_b == '0) &&
                        (out_weight_c == '0);
  assign weights_capped = (out_weight_a <= WEIGHT_ONE) && (out_weight_b <= WEIGHT_ONE) &&
                          (out_weight_c <= WEIGHT_ONE);

  // A held item keeps its whole payload.
  `TEB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit) && $stable(out_degenerate) && $stable(weight_sum) && $stable(out_weight_a) && $stable(out_weight_b), "stalled result changed")

  // Misses and flat triangles carry no weights.
  `TEB_ASSERT_SAME(a_no_weight, out_valid && (!out_hit || out_degenerate), weights_zero, "weights set on a miss or a flat triangle")

  // Each weight stays within one, and on a covered sample the three together
  // reach at least one (the third weight only clamps upward from below zero).
  `TEB_ASSERT_SAME(a_weight_range, out_valid, weights_capped, "weight above one")
  `TEB_ASSERT_SAME(a_weight_total, out_valid && out_hit && !out_degenerate, weight_sum >= SUM_ONE, "weights of a covered sample sum below one")

  // Nothing leaves the block in the cycle after reset.
  `TEB_ASSERT_RESET(a_reset_idle, !out_valid, "result shown right after reset")

endmodule

bind triangle_edge_barycentric_core teb_checker #(
  .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_teb_checker (.*);

// ===== tb/tb_triangle_edge_barycentric_core.sv =====
// Self-checking testbench for triangle_edge_barycentric_core: coverage flags and barycentric
// weights are predicted per sample point and compared with every result. Depends on teb_pkg.
`timescale 1ns / 100ps

module tb_triangle_edge_barycentric_core;
  import teb_pkg::*;

  localparam int WFB = 16;
  localparam longint WEIGHT_ONE = longint'(1) << WFB;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;
  localparam int COORD_MIN = -32768;
  localparam int COORD_MAX = 32767;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } sample_t;

  typedef struct packed {
    logic         hit;
    logic         degenerate;
    logic [WFB:0] weight_a;
    logic [WFB:0] weight_b;
    logic [WFB:0] weight_c;
  } coverage_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_sample_x = '0;
  logic [COORD_W-1:0]   in_sample_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic                 out_degenerate;
  logic [WFB:0]         out_weight_a;
  logic [WFB:0]         out_weight_b;
  logic [WFB:0]         out_weight_c;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  sample_t     sample_queue[$];
  coverage_t   pending_cover[$];
  vertex_set_t tri_regs = '0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          bad_results = 0;
  bit          hold_arm = 1'b0;
  logic        long_hold = 1'b0;

  triangle_edge_barycentric_core #(
    .WEIGHT_FRAC_BITS(WFB)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_degenerate (out_degenerate),
    .out_weight_a   (out_weight_a),
    .out_weight_b   (out_weight_b),
    .out_weight_c   (out_weight_c),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 10)) : 0;
  endfunction

  // Twice the signed area; negative for the winding that the block accepts.
  function automatic longint signed_area(vertex_set_t v);
    return (longint'(v.by) - v.cy) * (longint'(v.ax) - v.cx)
         + (longint'(v.cx) - v.bx) * (longint'(v.ay) - v.cy);
  endfunction

  function automatic logic [WFB:0] quotient_weight(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    if (den == 0 || num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    // Round to nearest with ties going up.
    q = ((n << WFB) + (d >> 1)) / d;
    return (q > WEIGHT_ONE) ? WEIGHT_ONE[WFB:0] : q[WFB:0];
  endfunction

  function automatic coverage_t cover_and_weigh(vertex_set_t v, coord_t x, coord_t y);
    longint ax, ay, bx, by, cx, cy, px, py;
    longint e_ab, e_bc, e_ca, area, wc;
    coverage_t r;
    ax = v.ax; ay = v.ay; bx = v.bx; by = v.by; cx = v.cx; cy = v.cy;
    px = x;
    py = y;
    r = '0;
    e_ab = (ax - bx) * (py - ay) - (ay - by) * (px - ax);
    e_bc = (bx - cx) * (py - by) - (by - cy) * (px - bx);
    e_ca = (cx - ax) * (py - cy) - (cy - ay) * (px - cx);
    area = signed_area(v);
    r.hit = (e_ab >= 0) && (e_bc >= 0) && (e_ca >= 0);
    r.degenerate = (area == 0);
    if (r.hit && !r.degenerate) begin
      r.weight_a = quotient_weight((by - cy) * (px - cx) + (cx - bx) * (py - cy), area);
      r.weight_b = quotient_weight((cy - ay) * (px - cx) + (ax - cx) * (py - cy), area);
      wc = WEIGHT_ONE - longint'(r.weight_a) - longint'(r.weight_b);
      r.weight_c = (wc < 0) ? '0 : wc[WFB:0];
    end
    return r;
  endfunction

  // Sender: one item at a time from the queue, with a random gap after each.
  always @(posedge clk) begin : feed
    sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_cover.push_back(cover_and_weigh(tri_regs, in_sample_x, in_sample_y));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          nxt = sample_queue.pop_front();
          in_sample_x <= nxt.x;
          in_sample_y <= nxt.y;
          in_valid <= 1'b1;
          send_gap = draw_gap(in_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : collect
    coverage_t got;
    coverage_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_hit, out_degenerate, out_weight_a, out_weight_b, out_weight_c};
        if (pending_cover.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("%0t: unexpected result hit=%0b degen=%0b w=%0d/%0d/%0d", $realtime,
                     got.hit, got.degenerate, got.weight_a, got.weight_b, got.weight_c);
          end
        end else begin
          want = pending_cover.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: mismatch hit %0b/%0b degen %0b/%0b wa %0d/%0d wb %0d/%0d wc %0d/%0d",
                       $realtime, want.hit, got.hit, want.degenerate, got.degenerate,
                       want.weight_a, got.weight_a, want.weight_b, got.weight_b,
                       want.weight_c, got.weight_c);
            end
          end
        end
        recv_gap = draw_gap(out_idle_pct);
      end
      out_stall <= long_hold || (recv_gap > 0);
      if (recv_gap > 0) recv_gap--;
    end
  end

  // One long hold-off at the output so that the pipeline fills and stalls its input.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_triangle_edge_barycentric_core failed");
    $finish;
  end

  task automatic write_vertex_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[COORD_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_A_X: tri_regs.ax = value[COORD_W-1:0];
      REG_A_Y: tri_regs.ay = value[COORD_W-1:0];
      REG_B_X: tri_regs.bx = value[COORD_W-1:0];
      REG_B_Y: tri_regs.by = value[COORD_W-1:0];
      REG_C_X: tri_regs.cx = value[COORD_W-1:0];
      REG_C_Y: tri_regs.cy = value[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_triangle(input int ax, ay, bx, by, cx, cy);
    write_vertex_reg(REG_A_X, ax);
    write_vertex_reg(REG_A_Y, ay);
    write_vertex_reg(REG_B_X, bx);
    write_vertex_reg(REG_B_Y, by);
    write_vertex_reg(REG_C_X, cx);
    write_vertex_reg(REG_C_Y, cy);
  endtask

  task automatic push_sample(input int x, input int y);
    sample_t s;
    s.x = x[COORD_W-1:0];
    s.y = y[COORD_W-1:0];
    sample_queue.push_back(s);
  endtask

  // Checked on the falling edge, where the sender's and receiver's updates have settled.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid || pending_cover.size() != 0) @(negedge clk);
  endtask

  function automatic int pick_coord(int center, int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // A random triangle, mostly in the accepted winding, then samples mostly from its
  // bounding box so that hits, edges and misses all come up often.
  task automatic random_phase(input int n_items);
    int vx[3];
    int vy[3];
    int center_x, center_y, span, sel, tmp;
    int min_x, max_x, min_y, max_y, k;
    vertex_set_t t;
    sel = $urandom_range(0, 9);
    span = (sel < 5) ? $urandom_range(8, 256) :
           (sel < 8) ? $urandom_range(257, 4096) : 32768;
    center_x = (sel < 8) ? int'($urandom_range(0, 65535)) - 32768 : 0;
    center_y = (sel < 8) ? int'($urandom_range(0, 65535)) - 32768 : 0;
    for (k = 0; k < 3; k++) begin
      vx[k] = pick_coord(center_x, span);
      vy[k] = pick_coord(center_y, span);
    end
    if ($urandom_range(0, 19) == 0) begin
      vx[2] = vx[0];
      vy[2] = vy[0];
    end
    t.ax = vx[0]; t.ay = vy[0]; t.bx = vx[1]; t.by = vy[1]; t.cx = vx[2]; t.cy = vy[2];
    if (signed_area(t) > 0 && $urandom_range(0, 4) != 0) begin
      tmp = vx[1]; vx[1] = vx[2]; vx[2] = tmp;
      tmp = vy[1]; vy[1] = vy[2]; vy[2] = tmp;
    end
    set_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    min_x = vx[0]; max_x = vx[0]; min_y = vy[0]; max_y = vy[0];
    for (k = 1; k < 3; k++) begin
      if (vx[k] < min_x) min_x = vx[k];
      if (vx[k] > max_x) max_x = vx[k];
      if (vy[k] < min_y) min_y = vy[k];
      if (vy[k] > max_y) max_y = vy[k];
    end
    for (k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        push_sample(min_x + int'($urandom_range(0, max_x - min_x)),
                    min_y + int'($urandom_range(0, max_y - min_y)));
      end else if (sel < 80) begin
        tmp = $urandom_range(0, 2);
        push_sample(vx[tmp], vy[tmp]);
      end else begin
        push_sample(int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768);
      end
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 30;
    out_idle_pct = 30;

    // All vertices at the origin after reset: every edge function is zero.
    push_sample(0, 0);
    push_sample(COORD_MAX, COORD_MIN);
    push_sample(COORD_MIN, COORD_MAX);
    wait_idle();

    // Small triangle in the accepted winding: vertices, an edge, inside, outside.
    set_triangle(0, 0, 0, 16, 16, 0);
    push_sample(0, 0);
    push_sample(0, 16);
    push_sample(16, 0);
    push_sample(8, 0);
    push_sample(4, 4);
    push_sample(5, 5);
    push_sample(17, 0);
    push_sample(-1, 0);
    wait_idle();

    // Largest triangle the coordinates allow.
    set_triangle(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    push_sample(COORD_MIN, COORD_MIN);
    push_sample(COORD_MAX, COORD_MAX);
    push_sample(COORD_MAX, COORD_MIN);
    push_sample(0, 0);
    push_sample(COORD_MIN, COORD_MAX);
    wait_idle();

    // Collinear vertices give zero area whether the sample hits or not.
    set_triangle(0, 0, 16, 16, 32, 32);
    push_sample(16, 16);
    push_sample(0, 16);
    wait_idle();

    // Writes to indexes past the last register must leave the triangle alone.
    set_triangle(0, 0, 0, 16, 16, 0);
    write_vertex_reg(IDX_SPARE_6, COORD_MAX);
    write_vertex_reg(IDX_SPARE_7, COORD_MIN);
    push_sample(4, 4);
    push_sample(8, 8);
    wait_idle();

    for (p = 0; p < 10; p++) begin
      in_idle_pct = (p == 0) ? 0 : (p == 2) ? 5 : $urandom_range(0, 70);
      out_idle_pct = (p == 0) ? 0 : $urandom_range(0, 70);
      random_phase(143);
      if (p == 2) hold_arm = 1'b1;
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (bad_results == 0) begin
      $display("tb_triangle_edge_barycentric_core passed");
    end else begin
      $display("tb_triangle_edge_barycentric_core failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/teb_pkg.sv
hw/rtl/teb_cfg_regs.sv
hw/rtl/teb_edge_pipe.sv
hw/rtl/teb_div_pipe.sv
hw/rtl/triangle_edge_barycentric_core.sv
hw/rtl/teb_checker.sv
tb/tb_triangle_edge_barycentric_core.sv
